// ----- sv/hrlp_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// HTTP request line parser package
// Shared constants, types and helper functions of the request line parser.
// ----------------------------------------------------------------------------
package hrlp_pkg;

    localparam int MAX_LINE = 4096;
    localparam int POS_W = $clog2(MAX_LINE);
    localparam int PTR_W = POS_W + 1;
    localparam int OUT_W = 12;

    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_AW = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CW = $clog2(QUEUE_DEPTH + 1);

    localparam logic [POS_W-1:0] POS_LAST = POS_W'(MAX_LINE - 1);

    localparam logic [7:0] CH_SP = 8'h20;
    localparam logic [7:0] CH_CR = 8'h0D;
    localparam logic [7:0] CH_LF = 8'h0A;
    localparam logic [7:0] CH_QMARK = 8'h3F;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_COLON = 8'h3A;

    localparam int NUM_METHODS = 5;

    localparam logic [2:0] METHOD_GET = 3'd0;
    localparam logic [2:0] METHOD_POST = 3'd1;
    localparam logic [2:0] METHOD_PUT = 3'd2;
    localparam logic [2:0] METHOD_DELETE = 3'd3;
    localparam logic [2:0] METHOD_HEAD = 3'd4;
    localparam logic [2:0] METHOD_UNKNOWN = 3'd5;

    localparam logic [7:0] METHOD_NAMES [NUM_METHODS][8] = '{
        '{8'h47, 8'h45, 8'h54, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h50, 8'h4F, 8'h53, 8'h54, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h50, 8'h55, 8'h54, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h44, 8'h45, 8'h4C, 8'h45, 8'h54, 8'h45, 8'h00, 8'h00},
        '{8'h48, 8'h45, 8'h41, 8'h44, 8'h00, 8'h00, 8'h00, 8'h00}
    };
    localparam logic [2:0] METHOD_LENS [NUM_METHODS] = '{3'd3, 3'd4, 3'd3, 3'd6, 3'd4};

    typedef enum logic [1:0] {
        PH_METHOD,
        PH_URL,
        PH_REST,
        PH_DONE
    } hrlp_phase_t;

    typedef struct packed {
        logic [2:0]       method_code;
        logic             url_started;
        logic [PTR_W-1:0] url_begin;
        logic [PTR_W-1:0] url_end;
        logic             scheme_found;
        logic             sas_found;
        logic [POS_W-1:0] sas;
        logic             fs_found;
        logic [POS_W-1:0] fs;
        logic             q_found;
        logic [POS_W-1:0] q;
        logic             complete;
        logic             overflow;
        logic [POS_W-1:0] pos;
    } hrlp_rec_t;

    typedef struct packed {
        logic full;
        logic empty;
    } hrlp_qstat_t;

    function automatic logic [2:0] pick_method(input logic [NUM_METHODS-1:0] cand,
                                               input logic [2:0] len);
        logic [2:0] code;
        code = METHOD_UNKNOWN;
        for (int k = NUM_METHODS - 1; k >= 0; k--) begin
            if (cand[k] && (METHOD_LENS[k] == len))
            begin
                code = 3'(k);
            end
        end
        return code;
    endfunction

    function automatic logic [NUM_METHODS-1:0] method_filter(
        input logic [NUM_METHODS-1:0] cand,
        input logic [2:0] len,
        input logic [7:0] b
    );
        logic [NUM_METHODS-1:0] res;
        res = cand;
        for (int k = 0; k < NUM_METHODS; k++) begin
            if (len >= METHOD_LENS[k])
            begin
                res[k] = 1'b0;
            end
            else if (METHOD_NAMES[k][len] != b)
            begin
                res[k] = 1'b0;
            end
        end
        return res;
    endfunction

    function automatic logic [OUT_W-1:0] to_out(input logic [PTR_W-1:0] v);
        logic [31:0] w;
        w = 32'(v);
        return w[OUT_W-1:0];
    endfunction

endpackage
`default_nettype wire

// ----- sv/hrlp_front.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Request line parser front end
// Accepts one byte per transfer, tracks the parse phase and the positions of
// interest, and pushes a result record at the line end, overflow or buffer end.
// ----------------------------------------------------------------------------
module hrlp_front (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    input  wire logic [7:0]          data_byte,
    input  wire logic                end_of_buffer,
    input  wire hrlp_pkg::hrlp_qstat_t qstat,
    output logic                     push,
    output hrlp_pkg::hrlp_rec_t      rec
);

    hrlp_pkg::hrlp_phase_t phase_reg, phase_next;

    logic [hrlp_pkg::POS_W-1:0]       pos_reg, pos_next;
    logic [hrlp_pkg::NUM_METHODS-1:0] cand_reg, cand_next;
    logic [2:0]                       mlen_reg, mlen_next;
    logic [2:0]                       mcode_reg, mcode_next;
    logic                             url_started_reg, url_started_next;
    logic [hrlp_pkg::PTR_W-1:0]       url_begin_reg, url_begin_next;
    logic [hrlp_pkg::POS_W-1:0]       url_end_reg, url_end_next;
    logic [1:0]                       sprog_reg, sprog_next;
    logic                             scheme_found_reg, scheme_found_next;
    logic                             fs_found_reg, fs_found_next;
    logic [hrlp_pkg::POS_W-1:0]       fs_reg, fs_next;
    logic                             sas_found_reg, sas_found_next;
    logic [hrlp_pkg::POS_W-1:0]       sas_reg, sas_next;
    logic                             q_found_reg, q_found_next;
    logic [hrlp_pkg::POS_W-1:0]       q_reg, q_next;
    logic                             prev_cr_reg, prev_cr_next;

    logic accept;
    logic is_sp;
    logic is_cr;
    logic complete_w;
    logic overflow_w;
    logic active;
    logic emit;
    logic url_open;
    logic [hrlp_pkg::PTR_W-1:0] pos_plus1;

    assign accept = in_valid && !qstat.full;
    assign is_sp = (data_byte == hrlp_pkg::CH_SP);
    assign is_cr = (data_byte == hrlp_pkg::CH_CR);
    assign active = (phase_reg != hrlp_pkg::PH_DONE);
    assign complete_w = (phase_reg == hrlp_pkg::PH_REST) && (data_byte == hrlp_pkg::CH_LF)
                        && prev_cr_reg && !overflow_w;
    assign overflow_w = (pos_reg >= hrlp_pkg::POS_LAST);
    assign emit = active && (complete_w || overflow_w || end_of_buffer);
    assign push = accept && emit;
    assign url_open = ((phase_reg == hrlp_pkg::PH_URL) && !(is_sp || is_cr))
                      || ((phase_reg == hrlp_pkg::PH_METHOD) && is_sp);
    assign pos_plus1 = {1'b0, pos_reg} + hrlp_pkg::PTR_W'(1);

    always_comb
    begin
        phase_next = phase_reg;
        if (accept)
        begin
            case (phase_reg)
                hrlp_pkg::PH_METHOD:
                begin
                    if (is_sp)
                    begin
                        phase_next = hrlp_pkg::PH_URL;
                    end
                    else if (is_cr)
                    begin
                        phase_next = hrlp_pkg::PH_REST;
                    end
                end
                hrlp_pkg::PH_URL:
                begin
                    if (is_sp || is_cr)
                    begin
                        phase_next = hrlp_pkg::PH_REST;
                    end
                end
                hrlp_pkg::PH_REST:
                begin
                    phase_next = hrlp_pkg::PH_REST;
                end
                default:
                begin
                    phase_next = hrlp_pkg::PH_DONE;
                end
            endcase
            if (emit)
            begin
                phase_next = hrlp_pkg::PH_DONE;
            end
            if (end_of_buffer)
            begin
                phase_next = hrlp_pkg::PH_METHOD;
            end
        end
    end

    always_comb
    begin
        pos_next = pos_reg;
        cand_next = cand_reg;
        mlen_next = mlen_reg;
        mcode_next = mcode_reg;
        url_started_next = url_started_reg;
        url_begin_next = url_begin_reg;
        url_end_next = url_end_reg;
        sprog_next = sprog_reg;
        scheme_found_next = scheme_found_reg;
        fs_found_next = fs_found_reg;
        fs_next = fs_reg;
        sas_found_next = sas_found_reg;
        sas_next = sas_reg;
        q_found_next = q_found_reg;
        q_next = q_reg;
        prev_cr_next = prev_cr_reg;

        if (accept && active)
        begin
            case (phase_reg)
                hrlp_pkg::PH_METHOD:
                begin
                    if (is_sp)
                    begin
                        mcode_next = hrlp_pkg::pick_method(cand_reg, mlen_reg);
                        url_started_next = 1'b1;
                        url_begin_next = pos_plus1;
                    end
                    else if (is_cr)
                    begin
                        mcode_next = hrlp_pkg::METHOD_UNKNOWN;
                    end
                    else
                    begin
                        cand_next = hrlp_pkg::method_filter(cand_reg, mlen_reg, data_byte);
                        if (mlen_reg != 3'd7)
                        begin
                            mlen_next = mlen_reg + 3'd1;
                        end
                    end
                end
                hrlp_pkg::PH_URL:
                begin
                    if (is_sp || is_cr)
                    begin
                        url_end_next = pos_reg;
                    end
                    else
                    begin
                        if ((data_byte == hrlp_pkg::CH_QMARK) && !q_found_reg)
                        begin
                            q_found_next = 1'b1;
                            q_next = pos_reg;
                        end
                        if ((data_byte == hrlp_pkg::CH_SLASH) && !fs_found_reg)
                        begin
                            fs_found_next = 1'b1;
                            fs_next = pos_reg;
                        end
                        if ((data_byte == hrlp_pkg::CH_SLASH) && scheme_found_reg
                            && !sas_found_reg)
                        begin
                            sas_found_next = 1'b1;
                            sas_next = pos_reg;
                        end
                        if (!scheme_found_reg)
                        begin
                            if ((sprog_reg != 2'd0) && (data_byte == hrlp_pkg::CH_SLASH))
                            begin
                                if (sprog_reg == 2'd2)
                                begin
                                    scheme_found_next = 1'b1;
                                    sprog_next = 2'd0;
                                end
                                else
                                begin
                                    sprog_next = sprog_reg + 2'd1;
                                end
                            end
                            else
                            begin
                                sprog_next = (data_byte == hrlp_pkg::CH_COLON) ? 2'd1 : 2'd0;
                            end
                        end
                    end
                end
                default:
                begin
                end
            endcase
            prev_cr_next = is_cr;
            if (!emit)
            begin
                pos_next = pos_reg + hrlp_pkg::POS_W'(1);
            end
        end

        rec.method_code = mcode_next;
        rec.url_started = url_started_next;
        rec.url_begin = url_begin_next;
        rec.url_end = url_open ? pos_plus1 : {1'b0, url_end_next};
        rec.scheme_found = scheme_found_next;
        rec.sas_found = sas_found_next;
        rec.sas = sas_next;
        rec.fs_found = fs_found_next;
        rec.fs = fs_next;
        rec.q_found = q_found_next;
        rec.q = q_next;
        rec.complete = complete_w;
        rec.overflow = overflow_w;
        rec.pos = pos_reg;

        if (accept && end_of_buffer)
        begin
            pos_next = '0;
            cand_next = '1;
            mlen_next = 3'd0;
            mcode_next = hrlp_pkg::METHOD_UNKNOWN;
            url_started_next = 1'b0;
            url_begin_next = '0;
            url_end_next = '0;
            sprog_next = 2'd0;
            scheme_found_next = 1'b0;
            fs_found_next = 1'b0;
            fs_next = '0;
            sas_found_next = 1'b0;
            sas_next = '0;
            q_found_next = 1'b0;
            q_next = '0;
            prev_cr_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= hrlp_pkg::PH_METHOD;
            pos_reg <= '0;
            cand_reg <= '1;
            mlen_reg <= 3'd0;
            mcode_reg <= hrlp_pkg::METHOD_UNKNOWN;
            url_started_reg <= 1'b0;
            url_begin_reg <= '0;
            url_end_reg <= '0;
            sprog_reg <= 2'd0;
            scheme_found_reg <= 1'b0;
            fs_found_reg <= 1'b0;
            fs_reg <= '0;
            sas_found_reg <= 1'b0;
            sas_reg <= '0;
            q_found_reg <= 1'b0;
            q_reg <= '0;
            prev_cr_reg <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            pos_reg <= pos_next;
            cand_reg <= cand_next;
            mlen_reg <= mlen_next;
            mcode_reg <= mcode_next;
            url_started_reg <= url_started_next;
            url_begin_reg <= url_begin_next;
            url_end_reg <= url_end_next;
            sprog_reg <= sprog_next;
            scheme_found_reg <= scheme_found_next;
            fs_found_reg <= fs_found_next;
            fs_reg <= fs_next;
            sas_found_reg <= sas_found_next;
            sas_reg <= sas_next;
            q_found_reg <= q_found_next;
            q_reg <= q_next;
            prev_cr_reg <= prev_cr_next;
        end
    end

    // A result without the end of the buffer leaves the parser waiting for it.
    assert property (@(posedge clk) disable iff (!rst_n)
        (push && !end_of_buffer) |=> (phase_reg == hrlp_pkg::PH_DONE))
        else $error("front: phase not done after a result");

    // Once a result is out, nothing more is pushed until the buffer ends.
    assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == hrlp_pkg::PH_DONE) |-> !push)
        else $error("front: push while waiting for end of buffer");

endmodule
`default_nettype wire

// ----- sv/hrlp_queue.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Request line parser result queue
// A short queue of result records between the front end and the back end.
// ----------------------------------------------------------------------------
module hrlp_queue (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  push,
    input  wire hrlp_pkg::hrlp_rec_t   wr_rec,
    input  wire logic                  pop,
    output hrlp_pkg::hrlp_rec_t        rd_rec,
    output hrlp_pkg::hrlp_qstat_t      qstat
);

    hrlp_pkg::hrlp_rec_t mem [hrlp_pkg::QUEUE_DEPTH];

    logic [hrlp_pkg::QUEUE_AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [hrlp_pkg::QUEUE_AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [hrlp_pkg::QUEUE_CW-1:0] count_reg, count_next;

    localparam logic [hrlp_pkg::QUEUE_AW-1:0] PTR_LAST =
        hrlp_pkg::QUEUE_AW'(hrlp_pkg::QUEUE_DEPTH - 1);
    localparam logic [hrlp_pkg::QUEUE_CW-1:0] COUNT_FULL =
        hrlp_pkg::QUEUE_CW'(hrlp_pkg::QUEUE_DEPTH);

    assign qstat.full = (count_reg == COUNT_FULL);
    assign qstat.empty = (count_reg == '0);
    assign rd_rec = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + hrlp_pkg::QUEUE_AW'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + hrlp_pkg::QUEUE_AW'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + hrlp_pkg::QUEUE_CW'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - hrlp_pkg::QUEUE_CW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= wr_rec;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg <= count_next;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !qstat.full)
        else $error("queue: push while full");

    assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !qstat.empty)
        else $error("queue: pop while empty");

endmodule
`default_nettype wire

// ----- sv/hrlp_back.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Request line parser back end
// Turns a result record into URL, path, query and header fields and holds
// them in the output register until the transfer completes.
// ----------------------------------------------------------------------------
module hrlp_back (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire hrlp_pkg::hrlp_rec_t rec,
    input  wire hrlp_pkg::hrlp_qstat_t qstat,
    output logic                     pop,
    input  wire logic                out_stall,
    output logic                     out_valid,
    output logic [2:0]               method_code,
    output logic [11:0]              url_offset,
    output logic [11:0]              url_length,
    output logic [11:0]              path_offset,
    output logic [11:0]              path_length,
    output logic                     path_is_default,
    output logic [11:0]              query_offset,
    output logic [11:0]              query_length,
    output logic [11:0]              header_offset,
    output logic                     line_complete,
    output logic                     line_overflow
);

    logic out_valid_reg, out_valid_next;

    logic [2:0]  method_code_reg;
    logic [11:0] url_offset_reg, url_offset_next;
    logic [11:0] url_length_reg, url_length_next;
    logic [11:0] path_offset_reg, path_offset_next;
    logic [11:0] path_length_reg, path_length_next;
    logic        path_is_default_reg, path_is_default_next;
    logic [11:0] query_offset_reg, query_offset_next;
    logic [11:0] query_length_reg, query_length_next;
    logic [11:0] header_offset_reg, header_offset_next;
    logic        line_complete_reg;
    logic        line_overflow_reg;

    logic                       have_start;
    logic [hrlp_pkg::PTR_W-1:0] start;
    logic [hrlp_pkg::PTR_W-1:0] qpos;
    logic [hrlp_pkg::PTR_W-1:0] pend;
    logic [hrlp_pkg::PTR_W-1:0] qoff;

    assign pop = !qstat.empty && (!out_valid_reg || !out_stall);

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (pop)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_comb
    begin
        have_start = rec.scheme_found ? rec.sas_found : rec.fs_found;
        start = rec.scheme_found ? {1'b0, rec.sas} : {1'b0, rec.fs};
        qpos = {1'b0, rec.q};
        pend = (rec.q_found && (qpos >= start)) ? qpos : rec.url_end;
        qoff = qpos + hrlp_pkg::PTR_W'(1);

        url_offset_next = '0;
        url_length_next = '0;
        path_offset_next = '0;
        path_length_next = 12'd1;
        path_is_default_next = 1'b1;
        query_offset_next = '0;
        query_length_next = '0;
        if (rec.url_started)
        begin
            url_offset_next = hrlp_pkg::to_out(rec.url_begin);
            url_length_next = hrlp_pkg::to_out(rec.url_end - rec.url_begin);
            if (have_start)
            begin
                path_is_default_next = 1'b0;
                path_offset_next = hrlp_pkg::to_out(start);
                path_length_next = hrlp_pkg::to_out(pend - start);
            end
            if (rec.q_found)
            begin
                query_offset_next = hrlp_pkg::to_out(qoff);
                query_length_next = hrlp_pkg::to_out(rec.url_end - qoff);
            end
        end
        header_offset_next = rec.complete
            ? hrlp_pkg::to_out({1'b0, rec.pos} + hrlp_pkg::PTR_W'(1)) : '0;
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            method_code_reg <= rec.method_code;
            url_offset_reg <= url_offset_next;
            url_length_reg <= url_length_next;
            path_offset_reg <= path_offset_next;
            path_length_reg <= path_length_next;
            path_is_default_reg <= path_is_default_next;
            query_offset_reg <= query_offset_next;
            query_length_reg <= query_length_next;
            header_offset_reg <= header_offset_next;
            line_complete_reg <= rec.complete;
            line_overflow_reg <= rec.overflow;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign method_code = method_code_reg;
    assign url_offset = url_offset_reg;
    assign url_length = url_length_reg;
    assign path_offset = path_offset_reg;
    assign path_length = path_length_reg;
    assign path_is_default = path_is_default_reg;
    assign query_offset = query_offset_reg;
    assign query_length = query_length_reg;
    assign header_offset = header_offset_reg;
    assign line_complete = line_complete_reg;
    assign line_overflow = line_overflow_reg;

    // A result held under stall is never replaced by the next one.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_stall) |-> !pop)
        else $error("back: result overwritten while stalled");

endmodule
`default_nettype wire

// ----- sv/http_request_line_parser_top.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// HTTP request line parser
// Parses the request line of an HTTP request that arrives one byte per
// transfer, and reports the method, URL, path, query and header offsets.
//
// The input channel takes one byte and an end_of_buffer flag per transfer.
// The output channel gives at most one result per buffer: at the CRLF that
// ends the request line, when the line reaches its maximum length, or at the
// last byte of the buffer. Later bytes of the buffer give no result.
// A byte is taken every cycle while in_stall is low. The record of a result
// enters the result queue at the transfer of the byte that caused it, and its
// fields are computed into the output register when the output stage takes
// the record from the queue. The two-entry queue between the parser and the
// output stage lets bytes keep flowing while out_stall holds a result; in_stall
// rises only when the queue holds two results. After reset the parser expects
// the first byte of a new buffer and the output channel is empty.
// ----------------------------------------------------------------------------
module http_request_line_parser_top (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [7:0]  data_byte,
    input  wire logic        end_of_buffer,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [2:0]       method_code,
    output logic [11:0]      url_offset,
    output logic [11:0]      url_length,
    output logic [11:0]      path_offset,
    output logic [11:0]      path_length,
    output logic             path_is_default,
    output logic [11:0]      query_offset,
    output logic [11:0]      query_length,
    output logic [11:0]      header_offset,
    output logic             line_complete,
    output logic             line_overflow
);

    hrlp_pkg::hrlp_qstat_t qstat;
    hrlp_pkg::hrlp_rec_t   wr_rec;
    hrlp_pkg::hrlp_rec_t   rd_rec;
    logic                  push;
    logic                  pop;

    assign in_stall = qstat.full;

    hrlp_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .data_byte     (data_byte),
        .end_of_buffer (end_of_buffer),
        .qstat         (qstat),
        .push          (push),
        .rec           (wr_rec)
    );

    hrlp_queue u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .wr_rec (wr_rec),
        .pop    (pop),
        .rd_rec (rd_rec),
        .qstat  (qstat)
    );

    hrlp_back u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .rec             (rd_rec),
        .qstat           (qstat),
        .pop             (pop),
        .out_stall       (out_stall),
        .out_valid       (out_valid),
        .method_code     (method_code),
        .url_offset      (url_offset),
        .url_length      (url_length),
        .path_offset     (path_offset),
        .path_length     (path_length),
        .path_is_default (path_is_default),
        .query_offset    (query_offset),
        .query_length    (query_length),
        .header_offset   (header_offset),
        .line_complete   (line_complete),
        .line_overflow   (line_overflow)
    );

endmodule
`default_nettype wire
